// ----- src/ilse_pkg.sv -----
// shared types, codes and defaults for the indexed list stack engine
`default_nettype none

package ilse_pkg;

	// default sizes
	localparam int ILSE_DEPTH      = 16;
	localparam int ILSE_ELEM_WIDTH = 32;

	// action codes
	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_WRITE  = 3'd1;
	localparam logic [2:0] ACT_READ   = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_PEEK   = 3'd4;
	localparam logic [2:0] ACT_POP    = 3'd5;
	localparam logic [2:0] ACT_CLEAR  = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// read address select
	localparam logic [1:0] RD_POS   = 2'd0;
	localparam logic [1:0] RD_TAIL  = 2'd1;
	localparam logic [1:0] RD_NEXT1 = 2'd2;
	localparam logic [1:0] RD_NEXT2 = 2'd3;

	// write address select
	localparam logic [1:0] WR_APPEND = 2'd0;
	localparam logic [1:0] WR_POS    = 2'd1;
	localparam logic [1:0] WR_SHIFT  = 2'd2;

	// entry count update
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	// result data source
	localparam logic [1:0] DS_ZERO = 2'd0;
	localparam logic [1:0] DS_RAM  = 2'd1;
	localparam logic [1:0] DS_HELD = 2'd2;

	// request transaction
	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         position;
		logic signed [31:0] value;
	} ilse_req_t;

	// result transaction
	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic [4:0]         count;
		logic               empty_res;
	} ilse_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       ptr_inc;
		logic [1:0] cnt_op;
		logic       cap_data;
		logic       issue;
		logic [1:0] status;
		logic [1:0] data_sel;
	} ilse_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] action;
		logic       full;
		logic       empty;
		logic       pos_ok;
		logic       has_next1;
		logic       has_next2;
	} ilse_stat_t;

endpackage

`default_nettype wire

// ----- src/indexed_list_stack_engine_core.sv -----
// top level of the indexed list stack engine: controller, datapath and checks
`default_nettype none

// Fixed-capacity list that doubles as a stack. A request is taken when start is
// high and busy is low; every request gives exactly one result, shown on rsp for
// one cycle with done high, and the receiver cannot stall it. Append, overwrite,
// clear and every rejected request pass through the execute state only; read,
// peek and pop also pass through a wait state, since the entry store has a
// registered read. Remove at an index with later entries then goes through the
// shift state, where they move down one word per cycle through the single read
// and single write port of the entry ram. A new request can be accepted in the
// cycle its predecessor's result is on rsp. Entries need no clearing after
// reset.
module indexed_list_stack_engine_core import ilse_pkg::*; #(
	parameter int DEPTH      = ILSE_DEPTH,
	parameter int ELEM_WIDTH = ILSE_ELEM_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire ilse_req_t req,
	output logic           busy,
	output logic           done,
	output ilse_rsp_t      rsp
);

	ilse_cmd_t  cmd;
	ilse_stat_t stat;

	ilse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ilse_dp #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	// results never come back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a rejected request returns zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.data == '0))
		else $error("nonzero data with error status");

	// a result is only issued while a request is in progress
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> busy)
		else $error("result issued while idle");

endmodule

`default_nettype wire

// ----- src/ilse_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module ilse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/ilse_ctrl.sv -----
// controller state machine for the indexed list stack engine
`default_nettype none

module ilse_ctrl import ilse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire ilse_stat_t stat,
	output ilse_cmd_t       cmd,
	output logic            busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rd_sel   = RD_POS;
		cmd.wr_sel   = WR_POS;
		cmd.cnt_op   = CNT_HOLD;
		cmd.status   = ST_OK;
		cmd.data_sel = DS_ZERO;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (stat.action)
					ACT_APPEND: begin
						cmd.issue = 1'b1;
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_APPEND;
							cmd.cnt_op = CNT_INC;
						end
					end
					ACT_WRITE: begin
						cmd.issue = 1'b1;
						if (stat.pos_ok) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_POS;
						end else begin
							cmd.status = ST_RANGE;
						end
					end
					ACT_READ, ACT_REMOVE: begin
						if (stat.pos_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_WAIT;
						end else begin
							cmd.issue  = 1'b1;
							cmd.status = ST_RANGE;
						end
					end
					ACT_PEEK, ACT_POP: begin
						if (stat.empty) begin
							cmd.issue  = 1'b1;
							cmd.status = ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_TAIL;
							state_d    = S_WAIT;
						end
					end
					ACT_CLEAR: begin
						cmd.issue  = 1'b1;
						cmd.cnt_op = CNT_CLR;
					end
					default: begin
						cmd.issue = 1'b1;
					end
				endcase
			end
			S_WAIT: begin
				// read data is back from the ram
				if (stat.action == ACT_REMOVE && stat.has_next1) begin
					cmd.cap_data = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_NEXT1;
					state_d      = S_SHIFT;
				end else begin
					cmd.issue    = 1'b1;
					cmd.data_sel = DS_RAM;
					if (stat.action inside {ACT_REMOVE, ACT_POP}) begin
						cmd.cnt_op = CNT_DEC;
					end
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				// move one entry down per cycle
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				if (stat.has_next2) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT2;
					cmd.ptr_inc = 1'b1;
				end else begin
					cmd.issue    = 1'b1;
					cmd.data_sel = DS_HELD;
					cmd.cnt_op   = CNT_DEC;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/ilse_dp.sv -----
// datapath: request register, entry ram, count, shift pointer and result register
`default_nettype none

module ilse_dp import ilse_pkg::*; #(
	parameter int DEPTH      = ILSE_DEPTH,
	parameter int ELEM_WIDTH = ILSE_ELEM_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ilse_req_t req,
	input  wire ilse_cmd_t cmd,
	output ilse_stat_t     stat,
	output logic           done,
	output ilse_rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ilse_req_t               req_q;
	logic [AW-1:0]           ptr_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_d;
	logic signed [31:0]      data_q;
	logic signed [31:0]      ram_word;
	logic signed [31:0]      rsp_data;
	ilse_rsp_t               rsp_q;
	logic                    done_q;
	logic [ELEM_WIDTH-1:0]   val_elem;
	logic [ELEM_WIDTH-1:0]   ram_rdata;
	logic [ELEM_WIDTH-1:0]   ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [AW-1:0]           ram_waddr;

	// request capture and shift pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			ptr_q <= AW'(req.position);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	// element conversions
	assign val_elem = ELEM_WIDTH'($signed(req_q.value));
	assign ram_word = 32'($signed(ram_rdata));

	// status towards the controller
	always_comb begin
		stat.action    = req_q.action;
		stat.full      = (count_q == CW'(DEPTH));
		stat.empty     = (count_q == '0);
		stat.pos_ok    = (32'(req_q.position) < 32'(count_q)) &&
		                 (32'(req_q.position) < 32'(DEPTH));
		stat.has_next1 = (32'(ptr_q) + 32'd1 < 32'(count_q));
		stat.has_next2 = (32'(ptr_q) + 32'd2 < 32'(count_q));
	end

	// ram read address
	always_comb begin
		case (cmd.rd_sel)
			RD_POS:   ram_raddr = AW'(req_q.position);
			RD_TAIL:  ram_raddr = AW'(count_q - CW'(1));
			RD_NEXT1: ram_raddr = ptr_q + AW'(1);
			RD_NEXT2: ram_raddr = ptr_q + AW'(2);
			default:  ram_raddr = '0;
		endcase
	end

	// ram write address and data
	always_comb begin
		ram_wdata = val_elem;
		case (cmd.wr_sel)
			WR_APPEND: ram_waddr = AW'(count_q);
			WR_POS:    ram_waddr = AW'(req_q.position);
			WR_SHIFT: begin
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
			end
			default:   ram_waddr = '0;
		endcase
	end

	ilse_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// entry count update
	always_comb begin
		case (cmd.cnt_op)
			CNT_INC: count_d = count_q + CW'(1);
			CNT_DEC: count_d = count_q - CW'(1);
			CNT_CLR: count_d = '0;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// removed element held while the tail shifts down
	always_ff @(posedge clk) begin
		if (cmd.cap_data) begin
			data_q <= ram_word;
		end
	end

	// result data select
	always_comb begin
		case (cmd.data_sel)
			DS_RAM:  rsp_data = ram_word;
			DS_HELD: rsp_data = data_q;
			default: rsp_data = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rsp_q.data      <= rsp_data;
			rsp_q.status    <= cmd.status;
			rsp_q.count     <= 5'(count_d);
			rsp_q.empty_res <= (count_d == '0);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.issue;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ----- verif/ilse_list_checker.sv -----
// list predictor and result scoreboard for the indexed list stack engine
module ilse_list_checker import ilse_pkg::*; #(
	parameter int DEPTH = ILSE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire ilse_req_t req,
	input  wire logic      done,
	input  wire ilse_rsp_t rsp,
	output int             failures,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the list contents and fill level
	logic signed [31:0] shadow_entries [DEPTH];
	int unsigned        shadow_fill;

	// results predicted but not yet seen, oldest first
	ilse_rsp_t awaited_rsp [$];

	initial begin
		failures = 0;
		outstanding = 0;
		shadow_fill = 0;
		foreach (shadow_entries[i]) shadow_entries[i] = '0;
	end

	// apply one request to the shadow list and return the result it should give
	function automatic ilse_rsp_t list_response(input ilse_req_t r);
		ilse_rsp_t   res;
		int unsigned idx;
		logic        in_range;
		res = '0;
		res.status = ST_OK;
		in_range = (r.position < shadow_fill) && (r.position < DEPTH);
		case (r.action)
			ACT_APPEND: begin
				if (shadow_fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_entries[shadow_fill] = r.value;
					shadow_fill++;
				end
			end
			ACT_WRITE: begin
				if (in_range) shadow_entries[r.position] = r.value;
				else res.status = ST_RANGE;
			end
			ACT_READ: begin
				if (in_range) res.data = shadow_entries[r.position];
				else res.status = ST_RANGE;
			end
			ACT_REMOVE: begin
				if (in_range) begin
					res.data = shadow_entries[r.position];
					// later entries close the gap
					for (idx = r.position; idx + 1 < shadow_fill && idx + 1 < DEPTH; idx++)
						shadow_entries[idx] = shadow_entries[idx + 1];
					shadow_fill--;
				end else begin
					res.status = ST_RANGE;
				end
			end
			ACT_PEEK: begin
				if (shadow_fill == 0) res.status = ST_EMPTY;
				else res.data = shadow_entries[shadow_fill - 1];
			end
			ACT_POP: begin
				if (shadow_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = shadow_entries[shadow_fill - 1];
					shadow_fill--;
				end
			end
			ACT_CLEAR: begin
				shadow_fill = 0;
			end
			default: begin
			end
		endcase
		res.count = shadow_fill[4:0];
		res.empty_res = (shadow_fill == 0);
		return res;
	endfunction

	// retire results against the oldest prediction, then predict new transactions
	always @(posedge clk or negedge arst_n) begin
		ilse_rsp_t want;
		if (!arst_n) begin
			awaited_rsp.delete();
			shadow_fill = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$error("result with no request outstanding: data %0d status %0d count %0d",
						rsp.data, rsp.status, rsp.count);
					failures++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.data !== want.data) begin
						$error("data: expected %0d, actual %0d", want.data, rsp.data);
						failures++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						failures++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, rsp.count);
						failures++;
					end
					if (rsp.empty_res !== want.empty_res) begin
						$error("empty_res: expected %0d, actual %0d", want.empty_res,
							rsp.empty_res);
						failures++;
					end
				end
			end
			if (start && !busy) awaited_rsp.push_back(list_response(req));
			outstanding <= awaited_rsp.size();
		end
	end

endmodule

// ----- verif/indexed_list_stack_engine_core_test.sv -----
// stimulus, clock, reset and verdict for the indexed list stack engine
module indexed_list_stack_engine_core_test import ilse_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH         = ILSE_DEPTH;
	localparam int QUIET_LIMIT   = 1000;
	localparam int ITEMS_PER_MIX = 400;

	// action code the block must ignore
	localparam logic [2:0] ACT_UNUSED = 3'd7;

	typedef enum int {MIX_FILLING, MIX_DRAINING, MIX_CHURNING} traffic_mix_e;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	ilse_req_t req    = '0;
	logic      busy;
	logic      done;
	ilse_rsp_t rsp;

	int          failures;
	int          outstanding;
	int          quiet_cycles = 0;
	int unsigned gap_pct      = 0;
	logic [4:0]  seen_count   = '0;

	indexed_list_stack_engine_core #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ILSE_ELEM_WIDTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	ilse_list_checker #(
		.DEPTH (DEPTH)
	) list_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// last reported fill level, only used to steer positions
	always @(posedge clk) begin
		if (done) seen_count <= rsp.count;
	end

	// hang detection: cycles with neither a request nor a result transaction
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// element values with extra weight on the extremes
	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// action choice weighted by the current traffic mix
	function automatic logic [2:0] pick_action(input traffic_mix_e mix);
		int unsigned weights [8];
		int unsigned roll;
		int unsigned acc;
		case (mix)
			MIX_FILLING:  weights = '{45, 10, 15, 10, 8, 8, 2, 2};
			MIX_DRAINING: weights = '{15, 10, 15, 25, 10, 21, 2, 2};
			default:      weights = '{28, 14, 16, 16, 8, 14, 2, 2};
		endcase
		roll = $urandom_range(99);
		acc = 0;
		for (int a = 0; a < 8; a++) begin
			acc += weights[a];
			if (roll < acc) return a[2:0];
		end
		return ACT_UNUSED;
	endfunction

	// positions mostly inside the current list, sometimes anywhere
	function automatic logic [3:0] pick_position();
		int unsigned top;
		if (seen_count != 0 && $urandom_range(9) < 8) begin
			top = (seen_count > 16) ? 15 : seen_count - 1;
			return 4'($urandom_range(top));
		end
		return 4'($urandom_range(15));
	endfunction

	// optional sender gap, then hold the request until the block takes it
	task automatic issue_request(input logic [2:0] act, input logic [3:0] pos,
			input logic [31:0] val);
		ilse_req_t r;
		r.action = act;
		r.position = pos;
		r.value = val;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin
		traffic_mix_e mix;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases
		gap_pct = 6;
		issue_request(ACT_PEEK, 4'd0, pick_value());
		issue_request(ACT_POP, 4'd15, pick_value());
		issue_request(ACT_REMOVE, 4'd15, pick_value());
		issue_request(ACT_UNUSED, 4'd7, pick_value());
		// fill to capacity, then one append too many
		for (int i = 0; i < DEPTH; i++) issue_request(ACT_APPEND, 4'(i), pick_value());
		issue_request(ACT_APPEND, 4'd0, 32'h1234_5678);
		issue_request(ACT_WRITE, 4'd15, 32'h8000_0000);
		issue_request(ACT_READ, 4'd15, 32'h0);
		// longest shift, then the old last index is out of range
		issue_request(ACT_REMOVE, 4'd0, 32'hffff_ffff);
		issue_request(ACT_READ, 4'd15, 32'h0);
		issue_request(ACT_PEEK, 4'd3, 32'h0);
		issue_request(ACT_POP, 4'd9, 32'h0);
		issue_request(ACT_CLEAR, 4'd5, 32'h7fff_ffff);
		issue_request(ACT_READ, 4'd0, 32'h0);

		// random traffic: light sender gaps, heavy gaps, then back to back
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 6 : (phase == 1) ? 53 : 0;
			mix = MIX_CHURNING;
			for (int n = 0; n < ITEMS_PER_MIX; n++) begin
				if (n % 30 == 0) mix = traffic_mix_e'($urandom_range(2));
				issue_request(pick_action(mix), pick_position(), pick_value());
			end
		end

		// drain and settle
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2 * DEPTH) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
